@@ src/kpeg_pkg.sv @@
package kpeg_pkg;

   localparam int QUEUE_DEPTH = 8;
   localparam int RING_AW     = $clog2(QUEUE_DEPTH);
   localparam int NUM_KEYS    = 4;
   localparam int KEY_AW      = $clog2(NUM_KEYS);

   localparam logic [KEY_AW-1:0] KEY_UP   = 2'd0;
   localparam logic [KEY_AW-1:0] KEY_DOWN = 2'd1;
   localparam logic [KEY_AW-1:0] KEY_SET  = 2'd2;
   localparam logic [KEY_AW-1:0] KEY_BACK = 2'd3;

   localparam logic [2:0] EV_UP          = 3'd0;
   localparam logic [2:0] EV_DOWN        = 3'd1;
   localparam logic [2:0] EV_SET         = 3'd2;
   localparam logic [2:0] EV_BACK        = 3'd3;
   localparam logic [2:0] EV_SET_LONG    = 3'd4;
   localparam logic [2:0] EV_UP_REPEAT   = 3'd5;
   localparam logic [2:0] EV_DOWN_REPEAT = 3'd6;
   localparam logic [2:0] EV_NONE        = 3'd7;

   localparam logic       CMD_TICK   = 1'b0;
   localparam logic       CMD_INJECT = 1'b1;

   localparam logic [1:0] CSR_LONG_PRESS     = 2'd0;
   localparam logic [1:0] CSR_REPEAT_DELAY   = 2'd1;
   localparam logic [1:0] CSR_REPEAT_INTERVAL = 2'd2;

   typedef struct packed {
      logic       command;
      logic [3:0] key_pressed_mask;
      logic [2:0] injected_event;
   } req_type;

   typedef struct packed {
      logic [2:0] event_code;
      logic       last_event;
   } rsp_type;

   typedef struct packed {
      logic       pressed;
      logic [7:0] hold;
      logic [7:0] rep_count;
   } key_entry_type;

   typedef struct packed {
      logic       push;
      logic [2:0] push_code;
      logic       pop;
   } ring_ctl_type;

   typedef struct packed {
      logic       empty;
      logic       rd_last;
      logic [2:0] rd_code;
   } ring_stat_type;

   function automatic logic [7:0] sat_inc(input logic [7:0] v);
      sat_inc = (v == 8'hff) ? v : v + 8'd1;
   endfunction

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] p);
      ring_next = (p == RING_AW'(QUEUE_DEPTH - 1)) ? '0 : p + RING_AW'(1);
   endfunction

endpackage

@@ src/kpeg_key_store.sv @@
module kpeg_key_store import kpeg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KEY_AW-1:0]     rd_addr,
   input  logic                  wr_en,
   input  logic [KEY_AW-1:0]     wr_addr,
   input  key_entry_type         wr_data,
   output key_entry_type         rd_data
);

   key_entry_type           key_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]     valid_ff;
   logic [NUM_KEYS-1:0]     valid_in;
   key_entry_type           rd_ff;
   logic                    rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   // an entry not yet written reads as idle key
   assign rd_data = rd_valid_ff ? rd_ff : '0;

endmodule

@@ src/kpeg_event_ring.sv @@
module kpeg_event_ring import kpeg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  ring_ctl_type  ctl,
   output ring_stat_type stat
);

   logic [2:0]         ring_mem [QUEUE_DEPTH];
   logic [RING_AW-1:0] head_ff, head_in;
   logic [RING_AW-1:0] tail_ff, tail_in;
   logic [RING_AW-1:0] rd_addr;
   logic [2:0]         rd_ff;

   // read ahead to the following entry when popping
   assign rd_addr = ctl.pop ? ring_next(tail_ff) : tail_ff;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      if (ctl.push) begin
         head_in = ring_next(head_ff);
         // full ring drops its oldest entry
         if (ring_next(head_ff) == tail_ff) begin
            tail_in = ring_next(tail_ff);
         end
      end else if (ctl.pop) begin
         tail_in = ring_next(tail_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         ring_mem[head_ff] <= ctl.push_code;
      end
      rd_ff <= ring_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
      end
   end

   assign stat.empty   = (head_ff == tail_ff);
   assign stat.rd_last = (ring_next(tail_ff) == head_ff);
   assign stat.rd_code = rd_ff;

endmodule

@@ src/key_press_event_generator.sv @@
// channel   direction  handshake           payload
// req_      in         req_valid/req_stall  req_type (command, key mask, injected event)
// rsp_      out        rsp_valid/rsp_stall  rsp_type (event code, last event)
// csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// an inject request is done once it is accepted; a tick runs as:
// accept, a key store read-modify-write for each of the four keys (one key per cycle),
// a ring read, then one event per cycle from the ring read port while not stalled.
// reset is synchronous; it resets store valid bits, ring pointers and control registers.
// rsp_stall holds the drain; the next request is taken once the drain has finished.
module key_press_event_generator import kpeg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_KUPD   = 2'd1;
   localparam logic [1:0] ST_DSTART = 2'd2;
   localparam logic [1:0] ST_DOUT   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [KEY_AW-1:0] kidx_ff, kidx_in;
   logic [3:0]        mask_ff, mask_in;
   logic              lf_ff, lf_in;
   logic [7:0]        long_ff, long_in;
   logic [7:0]        delay_ff, delay_in;
   logic [7:0]        interval_ff, interval_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              req_acc;
   logic              csr_wr;
   logic              out_free;
   logic              rsp_load;

   logic [KEY_AW-1:0] key_rd_addr;
   key_entry_type     key_rd;
   key_entry_type     key_wr;
   logic              key_wr_en;

   ring_ctl_type      ring_ctl;
   ring_stat_type     ring_stat;

   logic              upd_push;
   logic [2:0]        upd_code;
   logic              lf_mid;

   kpeg_key_store u_key_store (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (key_rd_addr),
      .wr_en   (key_wr_en),
      .wr_addr (kidx_ff),
      .wr_data (key_wr),
      .rd_data (key_rd)
   );

   kpeg_event_ring u_event_ring (
      .clock (clock),
      .reset (reset),
      .ctl   (ring_ctl),
      .stat  (ring_stat)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_load  = (state_ff == ST_DOUT) && out_free;

   // key store is read one key ahead of the update
   assign key_rd_addr = (state_ff == ST_KUPD) ? kidx_ff + KEY_AW'(1) : KEY_UP;
   assign key_wr_en   = (state_ff == ST_KUPD);

   // per-key update
   always_comb begin
      logic       down;
      logic [7:0] r;
      down     = mask_ff[kidx_ff];
      key_wr   = key_rd;
      lf_mid   = lf_ff;
      upd_push = 1'b0;
      upd_code = {1'b0, kidx_ff};
      r        = '0;
      if (down) begin
         if (!key_rd.pressed) begin
            key_wr.pressed   = 1'b1;
            key_wr.hold      = 8'd1;
            key_wr.rep_count = '0;
            if (kidx_ff == KEY_SET) begin
               lf_mid = 1'b0;
            end
         end else begin
            key_wr.hold = sat_inc(key_rd.hold);
         end
         if (kidx_ff == KEY_SET) begin
            if (!lf_mid && key_wr.hold >= long_ff) begin
               upd_push = 1'b1;
               upd_code = EV_SET_LONG;
               lf_mid   = 1'b1;
            end
         end else if (kidx_ff == KEY_UP || kidx_ff == KEY_DOWN) begin
            if (key_wr.hold >= delay_ff) begin
               r = sat_inc(key_wr.rep_count);
               if (r >= interval_ff) begin
                  upd_push = 1'b1;
                  upd_code = (kidx_ff == KEY_UP) ? EV_UP_REPEAT : EV_DOWN_REPEAT;
                  r        = '0;
               end
               key_wr.rep_count = r;
            end
         end
      end else if (key_rd.pressed) begin
         // release gives the press event, except set after a long press
         if (kidx_ff != KEY_SET || !lf_mid) begin
            upd_push = 1'b1;
            upd_code = {1'b0, kidx_ff};
         end
         key_wr = '0;
         if (kidx_ff == KEY_SET) begin
            lf_mid = 1'b0;
         end
      end
   end

   always_comb begin
      ring_ctl.push      = 1'b0;
      ring_ctl.push_code = upd_code;
      ring_ctl.pop       = rsp_load;
      if (state_ff == ST_KUPD) begin
         ring_ctl.push = upd_push;
      end else if (req_acc && req_data.command == CMD_INJECT &&
                   req_data.injected_event != EV_NONE) begin
         ring_ctl.push      = 1'b1;
         ring_ctl.push_code = req_data.injected_event;
      end
   end

   always_comb begin
      state_in     = state_ff;
      kidx_in      = kidx_ff;
      mask_in      = mask_ff;
      lf_in        = (state_ff == ST_KUPD) ? lf_mid : lf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            kidx_in = KEY_UP;
            if (req_acc && req_data.command == CMD_TICK) begin
               mask_in  = req_data.key_pressed_mask;
               state_in = ST_KUPD;
            end
         end
         ST_KUPD: begin
            kidx_in = kidx_ff + KEY_AW'(1);
            if (kidx_ff == KEY_BACK) begin
               state_in = ST_DSTART;
            end
         end
         ST_DSTART: begin
            state_in = ring_stat.empty ? ST_IDLE : ST_DOUT;
         end
         ST_DOUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.event_code = ring_stat.rd_code;
               rsp_data_in.last_event = ring_stat.rd_last;
               if (ring_stat.rd_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      long_in     = long_ff;
      delay_in    = delay_ff;
      interval_in = interval_ff;
      if (csr_wr) begin
         case (csr_index)
            CSR_LONG_PRESS:      long_in     = csr_data;
            CSR_REPEAT_DELAY:    delay_in    = csr_data;
            CSR_REPEAT_INTERVAL: interval_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kidx_ff      <= KEY_UP;
         lf_ff        <= 1'b0;
         long_ff      <= 8'd10;
         delay_ff     <= 8'd5;
         interval_ff  <= 8'd2;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kidx_ff      <= kidx_in;
         lf_ff        <= lf_in;
         long_ff      <= long_in;
         delay_ff     <= delay_in;
         interval_ff  <= interval_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_push_in_drain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DSTART || state_ff == ST_DOUT) |-> !ring_ctl.push)
      else $error("event pushed while draining");

   a_last_empties_ring: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && ring_stat.rd_last) |=> ring_stat.empty)
      else $error("ring not empty after last event");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      ring_ctl.pop |-> !ring_stat.empty)
      else $error("pop from empty ring");

   a_key_sweep_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_KUPD && kidx_ff == KEY_BACK) |=> state_ff == ST_DSTART)
      else $error("key sweep did not hand over to drain");

endmodule
